### rtl/core/imf_pkg.sv
// shared types, codes and constants for the inbound message filter ring queue
// no dependencies; every other file in rtl/core except imf_ram imports this package
package imf_pkg;

    // default ring depth, handed to the top level parameter
    localparam int QUEUE_DEPTH_DEF = 64;

    // header format limits
    localparam int BATCH_MAX     = 32;
    localparam int MAX_NODES     = 64;
    localparam int HEADER_BYTES  = 32;
    localparam int MESSAGE_BYTES = 16;

    localparam int CAP_W      = 7;
    localparam int NODE_W     = 6;
    localparam int COUNT_W    = 6;
    localparam int META_W     = COUNT_W + NODE_W;
    localparam int NUM_CNT    = 7;
    localparam int CNT_W      = 3;
    localparam int CMDQ_DEPTH = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_OWN_NODE = 2'd1;
    localparam logic [1:0] CFG_EPOCH    = 2'd2;
    localparam logic [1:0] CFG_MASK     = 2'd3;

    // function codes
    localparam logic [1:0] FN_RECV    = 2'd0;
    localparam logic [1:0] FN_POP     = 2'd1;
    localparam logic [1:0] FN_SERVICE = 2'd2;
    localparam logic [1:0] FN_READ    = 2'd3;

    // header classes decided by the front end
    localparam logic [1:0] CLS_OK      = 2'd0;
    localparam logic [1:0] CLS_INVALID = 2'd1;
    localparam logic [1:0] CLS_STALE   = 2'd2;
    localparam logic [1:0] CLS_ECHO    = 2'd3;

    // statistics counter indexes
    localparam logic [CNT_W-1:0] CNT_RECEIVED = 3'd0;
    localparam logic [CNT_W-1:0] CNT_INVALID  = 3'd1;
    localparam logic [CNT_W-1:0] CNT_STALE    = 3'd2;
    localparam logic [CNT_W-1:0] CNT_ECHO     = 3'd3;
    localparam logic [CNT_W-1:0] CNT_FULL     = 3'd4;
    localparam logic [CNT_W-1:0] CNT_RESETS   = 3'd5;
    localparam logic [CNT_W-1:0] CNT_POPPED   = 3'd6;

    // result status codes
    localparam logic [3:0] STS_ACCEPTED   = 4'd0;
    localparam logic [3:0] STS_INVALID    = 4'd1;
    localparam logic [3:0] STS_STALE      = 4'd2;
    localparam logic [3:0] STS_ECHO       = 4'd3;
    localparam logic [3:0] STS_FULL       = 4'd4;
    localparam logic [3:0] STS_POPPED     = 4'd5;
    localparam logic [3:0] STS_EMPTY      = 4'd6;
    localparam logic [3:0] STS_RESET_DONE = 4'd7;
    localparam logic [3:0] STS_NO_RESET   = 4'd8;
    localparam logic [3:0] STS_COUNTER    = 4'd9;

    typedef struct packed {
        logic [1:0]        func;
        logic [15:0]       envelope_length;
        logic [15:0]       msg_count;
        logic [15:0]       header_flags;
        logic signed [15:0] header_source;
        logic [15:0]       envelope_source;
        logic [63:0]       header_epoch;
        logic [63:0]       batch_tag;
        logic [2:0]        counter_select;
    } t_cmd;

    typedef struct packed {
        logic [3:0]         status;
        logic [63:0]        out_batch_tag;
        logic [COUNT_W-1:0] out_msg_count;
        logic [NODE_W-1:0]  out_source;
        logic               reset_pending;
        logic [63:0]        counter_value;
    } t_res;

    // classified word passed from front end to back end
    typedef struct packed {
        logic [1:0]         func;
        logic [1:0]         cls;
        logic [63:0]        batch_tag;
        logic [COUNT_W-1:0] msg_count;
        logic [NODE_W-1:0]  source;
        logic [CNT_W-1:0]   counter_select;
    } t_job;

    typedef struct packed {
        logic [NODE_W-1:0] own_node;
        logic [63:0]       epoch_floor;
        logic [63:0]       known_nodes_mask;
    } t_filt_cfg;

endpackage

### rtl/core/inbound_message_filter_ring_queue_core.sv
// top level of the inbound message filter ring queue: configuration registers
// depends on imf_pkg, imf_front, imf_cmdq and imf_back

// Commands enter at a rising edge with i_start high and o_busy low; o_busy rises
// only while the two-word command queue between the header checker and the ring
// engine is full. Each command gives exactly one result, shown on o_res for one
// cycle with o_valid high; there is no back-pressure on the result side, so a
// result must be taken in that cycle. Receive, service and counter-read commands
// give their result in the cycle after the ring engine takes them. A pop of a
// non-empty ring needs a registered read of the ring memory and passes through
// the ST_POP state before its result is registered; while in ST_POP the ring
// engine takes no new command. Sustained rate is one command per cycle, except
// that each pop that returns an entry holds the ring engine in ST_POP.
// Configuration writes are taken at any edge with i_cfg_we high and are meant
// for an idle block; writing the capacity register empties the ring.
module inbound_message_filter_ring_queue_core #(
    parameter int QUEUE_DEPTH = imf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  imf_pkg::t_cmd i_cmd,
    output logic          o_valid,
    output imf_pkg::t_res o_res,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_data
);
    import imf_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    t_filt_cfg        r_cfg;
    logic             cap_wr;
    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             take;
    t_job             front_job;
    t_job             head_job;

    assign cap_wr = i_cfg_we && (i_cfg_idx == CFG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(64);
            r_cfg      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAPACITY: r_capacity             <= i_cfg_data[CAP_W-1:0];
                CFG_OWN_NODE: r_cfg.own_node         <= i_cfg_data[NODE_W-1:0];
                CFG_EPOCH:    r_cfg.epoch_floor      <= i_cfg_data;
                default:      r_cfg.known_nodes_mask <= i_cfg_data;
            endcase
        end
    end

    imf_front u_front (
        .i_start  (i_start),
        .i_q_full (q_full),
        .i_cmd    (i_cmd),
        .i_cfg    (r_cfg),
        .o_busy   (o_busy),
        .o_push   (push),
        .o_job    (front_job)
    );

    imf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (take),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    imf_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_cap_wr    (cap_wr),
        .i_job_valid (!q_empty),
        .i_job       (head_job),
        .o_job_take  (take),
        .o_valid     (o_valid),
        .o_res       (o_res)
    );

endmodule

### rtl/core/imf_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
module imf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/imf_front.sv
// front end: takes command words and classifies receive headers
// depends on imf_pkg; feeds imf_cmdq
module imf_front (
    input  logic               i_start,
    input  logic               i_q_full,
    input  imf_pkg::t_cmd      i_cmd,
    input  imf_pkg::t_filt_cfg i_cfg,
    output logic               o_busy,
    output logic               o_push,
    output imf_pkg::t_job      o_job
);
    import imf_pkg::*;

    // wide enough for header plus the largest batch length
    localparam int LW = 16 + $clog2(MESSAGE_BYTES + 1) + 1;

    logic [15:0]   src_raw;
    logic [LW-1:0] need_len;
    logic          bad_len;
    logic          bad_count;
    logic          bad_src;
    logic          invalid;

    assign o_busy = i_q_full;
    assign o_push = i_start && !i_q_full;

    always_comb begin
        src_raw   = $unsigned(i_cmd.header_source);
        need_len  = LW'(i_cmd.msg_count) * LW'(MESSAGE_BYTES) + LW'(HEADER_BYTES);
        bad_count = (i_cmd.msg_count == 16'd0) || (i_cmd.msg_count > 16'(BATCH_MAX));
        bad_len   = (i_cmd.envelope_length < 16'(HEADER_BYTES))
                 || (LW'(i_cmd.envelope_length) != need_len);
        bad_src   = src_raw[15] || (src_raw >= 16'(MAX_NODES))
                 || (i_cmd.envelope_source != src_raw)
                 || !i_cfg.known_nodes_mask[src_raw[5:0]];
        invalid   = bad_len || bad_count || (i_cmd.header_flags != 16'd0) || bad_src;

        o_job.func           = i_cmd.func;
        o_job.batch_tag      = i_cmd.batch_tag;
        o_job.msg_count      = i_cmd.msg_count[COUNT_W-1:0];
        o_job.source         = src_raw[NODE_W-1:0];
        o_job.counter_select = i_cmd.counter_select;

        priority if (invalid) begin
            o_job.cls = CLS_INVALID;
        end else if (i_cmd.header_epoch < i_cfg.epoch_floor) begin
            o_job.cls = CLS_STALE;
        end else if (src_raw == 16'(i_cfg.own_node)) begin
            o_job.cls = CLS_ECHO;
        end else begin
            o_job.cls = CLS_OK;
        end
    end

endmodule

### rtl/core/imf_cmdq.sv
// short queue of classified words between front end and back end
// depends on imf_pkg
module imf_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  imf_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output imf_pkg::t_job o_job
);
    import imf_pkg::*;

    localparam int AW = $clog2(CMDQ_DEPTH);

    t_job          r_mem [CMDQ_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_count;
    logic [AW-1:0] n_wp;
    logic [AW-1:0] n_rp;
    logic [AW:0]   n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == (AW+1)'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (do_push) begin
            n_wp = (r_wp == AW'(CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == AW'(CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

### rtl/core/imf_back.sv
// back end: ring queue, overflow flag and statistics counters
// depends on imf_pkg and imf_ram; drains imf_cmdq
module imf_back #(
    parameter int QUEUE_DEPTH = imf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [imf_pkg::CAP_W-1:0]  i_capacity,
    input  logic                       i_cap_wr,
    input  logic                       i_job_valid,
    input  imf_pkg::t_job              i_job,
    output logic                       o_job_take,
    output logic                       o_valid,
    output imf_pkg::t_res              o_res
);
    import imf_pkg::*;

    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CMPW = (PW + 1 > CAP_W) ? PW + 1 : CAP_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    logic                r_state;
    logic                n_state;
    logic [PW-1:0]       r_rp;
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       n_rp;
    logic [PW-1:0]       n_wp;
    logic                r_flag;
    logic                n_flag;
    logic [63:0]         r_cnt [NUM_CNT];
    logic                inc_en;
    logic [CNT_W-1:0]    inc_idx;
    logic                r_valid;
    logic                n_valid;
    t_res                r_res;
    t_res                n_res;

    logic [CMPW-1:0]     cap_ext;
    logic [PW:0]         cap_eff;
    logic [PW:0]         wp_inc;
    logic [PW:0]         rp_inc;
    logic [PW-1:0]       wp_next;
    logic [PW-1:0]       rp_next;
    logic                ring_we;
    logic                ring_re;
    logic [63:0]         tag_rdata;
    logic [META_W-1:0]   meta_rdata;

    // clamp capacity to 2..QUEUE_DEPTH
    always_comb begin
        cap_ext = CMPW'(i_capacity);
        priority if (cap_ext < CMPW'(2)) begin
            cap_eff = (PW+1)'(2);
        end else if (cap_ext > CMPW'(QUEUE_DEPTH)) begin
            cap_eff = (PW+1)'(QUEUE_DEPTH);
        end else begin
            cap_eff = cap_ext[PW:0];
        end
        wp_inc  = {1'b0, r_wp} + 1'b1;
        rp_inc  = {1'b0, r_rp} + 1'b1;
        wp_next = (wp_inc == cap_eff) ? '0 : wp_inc[PW-1:0];
        rp_next = (rp_inc == cap_eff) ? '0 : rp_inc[PW-1:0];
    end

    imf_ram #(
        .WIDTH (64),
        .DEPTH (QUEUE_DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wp),
        .i_wdata (i_job.batch_tag),
        .i_re    (ring_re),
        .i_raddr (r_rp),
        .o_rdata (tag_rdata)
    );

    imf_ram #(
        .WIDTH (META_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wp),
        .i_wdata ({i_job.source, i_job.msg_count}),
        .i_re    (ring_re),
        .i_raddr (r_rp),
        .o_rdata (meta_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_rp       = r_rp;
        n_wp       = r_wp;
        n_flag     = r_flag;
        inc_en     = 1'b0;
        inc_idx    = CNT_RECEIVED;
        ring_we    = 1'b0;
        ring_re    = 1'b0;
        o_job_take = 1'b0;
        n_valid    = 1'b0;
        n_res      = '0;

        if (r_state == ST_POP) begin
            // ring data for the pop arrives this cycle
            n_valid             = 1'b1;
            n_res.status        = STS_POPPED;
            n_res.out_batch_tag = tag_rdata;
            n_res.out_msg_count = meta_rdata[COUNT_W-1:0];
            n_res.out_source    = meta_rdata[META_W-1:COUNT_W];
            n_rp                = rp_next;
            inc_en              = 1'b1;
            inc_idx             = CNT_POPPED;
            n_state             = ST_IDLE;
        end else if (i_job_valid) begin
            o_job_take = 1'b1;
            unique case (i_job.func)
                FN_RECV: begin
                    n_valid = 1'b1;
                    inc_en  = 1'b1;
                    unique case (i_job.cls)
                        CLS_INVALID: begin
                            n_res.status = STS_INVALID;
                            inc_idx      = CNT_INVALID;
                        end
                        CLS_STALE: begin
                            n_res.status = STS_STALE;
                            inc_idx      = CNT_STALE;
                        end
                        CLS_ECHO: begin
                            n_res.status = STS_ECHO;
                            inc_idx      = CNT_ECHO;
                        end
                        default: begin
                            if (wp_next == r_rp) begin
                                n_res.status = STS_FULL;
                                inc_idx      = CNT_FULL;
                                n_flag       = 1'b1;
                            end else begin
                                n_res.status = STS_ACCEPTED;
                                inc_idx      = CNT_RECEIVED;
                                ring_we      = 1'b1;
                                n_wp         = wp_next;
                            end
                        end
                    endcase
                end
                FN_POP: begin
                    if (r_rp == r_wp) begin
                        n_valid      = 1'b1;
                        n_res.status = STS_EMPTY;
                    end else begin
                        ring_re = 1'b1;
                        n_state = ST_POP;
                    end
                end
                FN_SERVICE: begin
                    n_valid = 1'b1;
                    if (r_flag) begin
                        n_flag       = 1'b0;
                        inc_en       = 1'b1;
                        inc_idx      = CNT_RESETS;
                        n_res.status = STS_RESET_DONE;
                    end else begin
                        n_res.status = STS_NO_RESET;
                    end
                end
                default: begin
                    n_valid      = 1'b1;
                    n_res.status = STS_COUNTER;
                    if (i_job.counter_select < CNT_W'(NUM_CNT)) begin
                        n_res.counter_value = r_cnt[i_job.counter_select];
                    end
                end
            endcase
        end

        // capacity write empties the ring
        if (i_cap_wr) begin
            n_rp = '0;
            n_wp = '0;
        end
        n_res.reset_pending = n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rp    <= '0;
            r_wp    <= '0;
            r_flag  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_flag  <= n_flag;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_CNT; i++) begin
            if (!i_rst_n) begin
                r_cnt[i] <= '0;
            end else if (inc_en && inc_idx == CNT_W'(i)) begin
                r_cnt[i] <= r_cnt[i] + 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### tb/inbound_message_filter_ring_queue_core_test.sv
// self-checking bench for the inbound message filter ring queue core: directed words,
// then random phases under several register settings; needs imf_pkg and the core rtl
module inbound_message_filter_ring_queue_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import imf_pkg::*;

    localparam int RING_DEPTH  = QUEUE_DEPTH_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_WORDS = 150;
    localparam int NUM_PHASES  = 8;

    typedef enum {
        HDR_SHORT, HDR_ZERO_COUNT, HDR_BIG_COUNT, HDR_LENGTH, HDR_FLAGS, HDR_NEGATIVE,
        HDR_FAR_NODE, HDR_ENVELOPE, HDR_UNKNOWN, HDR_STALE, HDR_ECHO
    } t_defect;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    t_cmd        i_cmd = '0;
    logic        o_valid;
    t_res        o_res;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_CAPACITY;
    logic [63:0] i_cfg_data = '0;

    inbound_message_filter_ring_queue_core #(.QUEUE_DEPTH(RING_DEPTH)) dut (.*);

    // shadow of the registers and of the ring
    logic [CAP_W-1:0]   cfg_capacity;
    logic [NODE_W-1:0]  cfg_own;
    logic [63:0]        cfg_epoch;
    logic [63:0]        cfg_mask;
    logic [63:0]        ring_tag [RING_DEPTH];
    logic [COUNT_W-1:0] ring_count [RING_DEPTH];
    logic [NODE_W-1:0]  ring_source [RING_DEPTH];
    int                 head;
    int                 tail;
    logic               overflow_pending;
    logic [63:0]        stats [NUM_CNT];

    t_cmd cmd_pending [$];
    t_res expected_results [$];
    t_res want_res;
    int   n_queued = 0;
    int   n_taken = 0;
    int   n_errors = 0;
    int   n_settings = 0;
    int   seen_status [16];
    int   burst_left = 1;
    int   gap_left = 0;
    int   quiet_cycles = 0;
    logic taken;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int effective_capacity();
        if (cfg_capacity < 2) return 2;
        if (cfg_capacity > RING_DEPTH) return RING_DEPTH;
        return int'(cfg_capacity);
    endfunction

    function automatic logic [3:0] classify(t_cmd c);
        if (c.envelope_length < HEADER_BYTES) return STS_INVALID;
        if (c.msg_count == 0 || c.msg_count > BATCH_MAX) return STS_INVALID;
        if (int'(c.envelope_length) != HEADER_BYTES + int'(c.msg_count) * MESSAGE_BYTES)
            return STS_INVALID;
        // negative or beyond the last node
        if (c.header_flags != 0 || c.header_source[15:6] != 0) return STS_INVALID;
        if (c.envelope_source != c.header_source) return STS_INVALID;
        if (!cfg_mask[c.header_source[5:0]]) return STS_INVALID;
        if (c.header_epoch < cfg_epoch) return STS_STALE;
        if (c.header_source[5:0] == cfg_own) return STS_ECHO;
        return STS_ACCEPTED;
    endfunction

    function automatic t_res filter_and_queue(t_cmd c);
        t_res r;
        int   next;
        r = '0;
        case (c.func)
            FN_RECV: begin
                r.status = classify(c);
                if (r.status == STS_ACCEPTED) begin
                    next = (tail + 1) % effective_capacity();
                    if (next == head) begin
                        overflow_pending = 1'b1;
                        r.status = STS_FULL;
                    end else begin
                        ring_tag[tail]    = c.batch_tag;
                        ring_count[tail]  = c.msg_count[COUNT_W-1:0];
                        ring_source[tail] = c.header_source[NODE_W-1:0];
                        tail = next;
                    end
                end
                case (r.status)
                    STS_ACCEPTED: stats[CNT_RECEIVED] += 1;
                    STS_INVALID:  stats[CNT_INVALID] += 1;
                    STS_STALE:    stats[CNT_STALE] += 1;
                    STS_ECHO:     stats[CNT_ECHO] += 1;
                    default:      stats[CNT_FULL] += 1;
                endcase
            end
            FN_POP: begin
                if (head == tail) begin
                    r.status = STS_EMPTY;
                end else begin
                    r.status        = STS_POPPED;
                    r.out_batch_tag = ring_tag[head];
                    r.out_msg_count = ring_count[head];
                    r.out_source    = ring_source[head];
                    head = (head + 1) % effective_capacity();
                    stats[CNT_POPPED] += 1;
                end
            end
            FN_SERVICE: begin
                if (overflow_pending) begin
                    overflow_pending = 1'b0;
                    stats[CNT_RESETS] += 1;
                    r.status = STS_RESET_DONE;
                end else begin
                    r.status = STS_NO_RESET;
                end
            end
            default: begin
                r.status = STS_COUNTER;
                r.counter_value = (c.counter_select < NUM_CNT) ? stats[c.counter_select] : '0;
            end
        endcase
        r.reset_pending = overflow_pending;
        return r;
    endfunction

    // every field random, so unused fields still toggle
    function automatic t_cmd noise_cmd();
        t_cmd c;
        c.func            = 2'($urandom);
        c.envelope_length = 16'($urandom);
        c.msg_count       = 16'($urandom);
        c.header_flags    = 16'($urandom);
        c.header_source   = 16'($urandom);
        c.envelope_source = 16'($urandom);
        c.header_epoch    = rand64();
        c.batch_tag       = rand64();
        c.counter_select  = 3'($urandom);
        return c;
    endfunction

    function automatic t_cmd plain_cmd(logic [1:0] fn, logic [CNT_W-1:0] sel);
        t_cmd c;
        c = noise_cmd();
        c.func = fn;
        c.counter_select = sel;
        return c;
    endfunction

    // a known node other than our own, where one exists
    function automatic logic [NODE_W-1:0] pick_source();
        logic [NODE_W-1:0] options [$];
        for (int n = 0; n < MAX_NODES; n++)
            if (cfg_mask[n] && n != cfg_own) options.push_back(NODE_W'(n));
        if (options.size() == 0) return NODE_W'($urandom);
        return options[$urandom_range(options.size() - 1)];
    endfunction

    function automatic t_cmd good_header(logic [NODE_W-1:0] src, int count);
        t_cmd c;
        c = noise_cmd();
        c.func            = FN_RECV;
        c.msg_count       = 16'(count);
        c.envelope_length = 16'(HEADER_BYTES + count * MESSAGE_BYTES);
        c.header_flags    = '0;
        c.header_source   = 16'(src);
        c.envelope_source = 16'(src);
        // or-ing random bits can only raise the epoch
        c.header_epoch = ($urandom_range(2) == 0) ? cfg_epoch : (cfg_epoch | rand64());
        return c;
    endfunction

    function automatic t_cmd broken_header();
        t_cmd    c;
        t_defect d;
        c = good_header(pick_source(), $urandom_range(1, BATCH_MAX));
        d = t_defect'($urandom_range(int'(HDR_ECHO)));
        if (d == HDR_STALE && cfg_epoch == 0) d = HDR_ECHO;
        case (d)
            HDR_SHORT:      c.envelope_length = 16'($urandom_range(HEADER_BYTES - 1));
            HDR_ZERO_COUNT: begin
                c.msg_count = '0;
                c.envelope_length = 16'(HEADER_BYTES);
            end
            HDR_BIG_COUNT: begin
                c.msg_count = 16'($urandom_range(BATCH_MAX + 1, 16'hFFFF));
                c.envelope_length = 16'(HEADER_BYTES + int'(c.msg_count) * MESSAGE_BYTES);
            end
            // never a whole number of messages away
            HDR_LENGTH:     c.envelope_length += 16'($urandom_range(1, MESSAGE_BYTES - 1));
            HDR_FLAGS:      c.header_flags = 16'd1 << $urandom_range(15);
            HDR_NEGATIVE: begin
                c.header_source = 16'($urandom_range(16'h8000, 16'hFFFF));
                c.envelope_source = c.header_source;
            end
            HDR_FAR_NODE: begin
                c.header_source = 16'($urandom_range(MAX_NODES, 16'h7FFF));
                c.envelope_source = c.header_source;
            end
            HDR_ENVELOPE:   c.envelope_source ^= 16'd1 << $urandom_range(15);
            HDR_UNKNOWN: begin
                c.header_source = 16'($urandom_range(MAX_NODES - 1));
                c.envelope_source = c.header_source;
            end
            HDR_STALE:      c.header_epoch = rand64() % cfg_epoch;
            default: begin
                c.header_source = 16'(cfg_own);
                c.envelope_source = 16'(cfg_own);
            end
        endcase
        return c;
    endfunction

    function automatic t_cmd random_cmd(int pop_pct);
        int   roll;
        t_cmd c;
        roll = $urandom_range(99);
        c = noise_cmd();
        if (roll < pop_pct) c.func = FN_POP;
        else if (roll < pop_pct + 5) c.func = FN_SERVICE;
        else if (roll < pop_pct + 10) c.func = FN_READ;
        else if (roll < pop_pct + 24) c = broken_header();
        else if (roll < 96) c = good_header(pick_source(), $urandom_range(1, BATCH_MAX));
        // the rest stay fully random
        return c;
    endfunction

    task automatic send(t_cmd c);
        cmd_pending.push_back(c);
        n_queued++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_CAPACITY: begin
                cfg_capacity = val[CAP_W-1:0];
                head = 0;
                tail = 0;
            end
            CFG_OWN_NODE: cfg_own = val[NODE_W-1:0];
            CFG_EPOCH:    cfg_epoch = val;
            default:      cfg_mask = val;
        endcase
    endtask

    task automatic configure(logic [CAP_W-1:0] cap, logic [NODE_W-1:0] own,
                             logic [63:0] epoch, logic [63:0] mask);
        write_reg(CFG_CAPACITY, 64'(cap));
        write_reg(CFG_OWN_NODE, 64'(own));
        write_reg(CFG_EPOCH, epoch);
        write_reg(CFG_MASK, mask);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // sampled away from the active edge so the driver and monitor have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (n_taken != n_queued || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    // sender: bursts of words with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            taken = i_start && !o_busy;
            if (taken) begin
                expected_results.push_back(filter_and_queue(i_cmd));
                n_taken++;
            end
            if (taken || !i_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_start <= 1'b0;
                end else if (cmd_pending.size() != 0) begin
                    i_cmd   <= cmd_pending.pop_front();
                    i_start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // results come back in command order
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen_status[o_res.status]++;
            if (expected_results.size() == 0) begin
                $error("result word with nothing outstanding: status %0d", o_res.status);
                n_errors++;
            end else begin
                want_res = expected_results.pop_front();
                check_field("status", 64'(want_res.status), 64'(o_res.status));
                check_field("out_batch_tag", want_res.out_batch_tag, o_res.out_batch_tag);
                check_field("out_msg_count", 64'(want_res.out_msg_count),
                            64'(o_res.out_msg_count));
                check_field("out_source", 64'(want_res.out_source), 64'(o_res.out_source));
                check_field("reset_pending", 64'(want_res.reset_pending),
                            64'(o_res.reset_pending));
                check_field("counter_value", want_res.counter_value, o_res.counter_value);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("inbound_message_filter_ring_queue_core_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_cmd hdr;
        int   pop_pct;
        cfg_capacity = CAP_W'(RING_DEPTH);
        cfg_own = '0;
        cfg_epoch = '0;
        cfg_mask = '0;
        head = 0;
        tail = 0;
        overflow_pending = 1'b0;
        foreach (stats[k]) stats[k] = '0;
        foreach (seen_status[k]) seen_status[k] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ring of four, own node five, node nine unknown
        configure(7'd4, 6'd5, 64'd100, ~(64'd1 << 9));
        send(plain_cmd(FN_READ, 3'd7));
        send(plain_cmd(FN_POP, '0));
        send(plain_cmd(FN_SERVICE, '0));
        hdr = good_header(6'd0, 1);
        hdr.header_epoch = cfg_epoch;
        hdr.batch_tag = '0;
        send(hdr);
        hdr = good_header(6'd63, BATCH_MAX);
        hdr.header_epoch = '1;
        hdr.batch_tag = '1;
        send(hdr);
        send(good_header(6'd17, 5));
        // three entries fill a ring of four, so this one overflows
        send(good_header(6'd20, 3));
        send(plain_cmd(FN_SERVICE, '0));
        hdr = good_header(6'd1, 1);
        hdr.envelope_length = '0;
        send(hdr);
        hdr.envelope_length = 16'(HEADER_BYTES - 1);
        send(hdr);
        hdr.msg_count = '0;
        hdr.envelope_length = 16'(HEADER_BYTES);
        send(hdr);
        hdr.msg_count = 16'(BATCH_MAX + 1);
        hdr.envelope_length = 16'(HEADER_BYTES + (BATCH_MAX + 1) * MESSAGE_BYTES);
        send(hdr);
        hdr.msg_count = '1;
        hdr.envelope_length = '1;
        send(hdr);
        hdr = good_header(6'd2, 2);
        hdr.envelope_length += 16'(MESSAGE_BYTES);
        send(hdr);
        hdr = good_header(6'd2, 2);
        hdr.header_flags = 16'h8000;
        send(hdr);
        hdr = good_header(6'd2, 2);
        hdr.header_source = -16'sd1;
        hdr.envelope_source = '1;
        send(hdr);
        hdr.header_source = 16'sd64;
        hdr.envelope_source = 16'd64;
        send(hdr);
        hdr = good_header(6'd3, 2);
        hdr.envelope_source = 16'h0103;
        send(hdr);
        send(good_header(6'd9, 4));
        hdr = good_header(6'd4, 4);
        hdr.header_epoch = cfg_epoch - 1;
        send(hdr);
        send(good_header(6'd5, 4));
        repeat (4) send(plain_cmd(FN_POP, '0));
        for (int k = 0; k < NUM_CNT; k++) send(plain_cmd(FN_READ, CNT_W'(k)));
        wait_idle();

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            case (ph)
                1: configure(7'd64, 6'd0, '0, '1);
                2: configure(7'd2, 6'd63, rand64() >> $urandom_range(63), '1);
                3: configure(7'd0, 6'($urandom), '0, rand64() | rand64());
                4: configure(7'd127, 6'($urandom), '1, '1);
                5: configure(7'd1, 6'd0, rand64() >> 8, '0);
                6: configure(7'd65, 6'($urandom), rand64() >> 1, rand64());
                7: configure(7'($urandom_range(2, RING_DEPTH)), 6'd63, '0,
                             ~(64'd1 << $urandom_range(63)));
                default: configure(7'($urandom), 6'($urandom),
                                   rand64() >> $urandom_range(63), '1);
            endcase
            pop_pct = $urandom_range(5, 40);
            repeat (PHASE_WORDS) send(random_cmd(pop_pct));
            wait_idle();
        end
        repeat (10) @(posedge i_clk);

        $display("%0d command words under %0d register settings: %0d queued, %0d full,",
                 n_taken, n_settings, seen_status[STS_ACCEPTED], seen_status[STS_FULL]);
        $display("%0d popped, %0d empty; dropped %0d invalid, %0d stale, %0d echo;",
                 seen_status[STS_POPPED], seen_status[STS_EMPTY], seen_status[STS_INVALID],
                 seen_status[STS_STALE], seen_status[STS_ECHO]);
        $display("%0d overflow resets, %0d counter reads",
                 seen_status[STS_RESET_DONE], seen_status[STS_COUNTER]);
        if (n_errors == 0) begin
            $display("inbound_message_filter_ring_queue_core_test: done, clean");
        end else begin
            $display("inbound_message_filter_ring_queue_core_test: done, errors");
        end
        $finish;
    end

endmodule
